### design/skaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skaf_pkg: shared types and constants for the Kalman angle fusion block
// Controller states, datapath command bundle, register map and reset values.
// ----------------------------------------------------------------------------
package skaf_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = 4;
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

	// register map, index = paddr[3:2]
	localparam logic [1:0] REG_PROC_NOISE    = 2'd0;
	localparam logic [1:0] REG_MEAS_NOISE    = 2'd1;
	localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

	localparam logic [DATA_W-1:0] RST_PROC_NOISE    = 32'd4295;
	localparam logic [DATA_W-1:0] RST_MEAS_NOISE    = 32'd1503238554;
	localparam logic [DATA_W-1:0] RST_SAMPLE_PERIOD = 32'd21474836;
	localparam logic [DATA_W-1:0] RST_COVARIANCE    = 32'd4295;

	localparam logic signed [34:0] SUM_MAX = 35'sd2147483647;
	localparam logic signed [34:0] SUM_MIN = -35'sd2147483648;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRED,
		ST_PADD,
		ST_DIV,
		ST_GAIN,
		ST_GMUL,
		ST_UPD,
		ST_CMUL,
		ST_COV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic init_est;
		logic pred_mul;
		logic p_load;
		logic pred_add;
		logic div_init;
		logic div_step;
		logic k_set;
		logic gain_mul;
		logic gain_add;
		logic cov_mul;
		logic cov_upd;
		logic out_load;
	} cmd_t;

	// saturating add of a shifted product onto a Q16.16 value
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
			input logic signed [33:0] inc);
		logic signed [34:0] sum;
		sum = {{3{base[31]}}, base} + {inc[33], inc};
		if (sum > SUM_MAX) begin
			return 32'sh7fffffff;
		end else if (sum < SUM_MIN) begin
			return 32'sh80000000;
		end
		return sum[31:0];
	endfunction

endpackage
`default_nettype wire

### design/skaf_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skaf_regs: configuration register file
// APB-style write/read of Q, R and sample period.
// ----------------------------------------------------------------------------
module skaf_regs
	import skaf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output logic      [DATA_W-1:0] proc_noise,
	output logic      [DATA_W-1:0] meas_noise,
	output logic      [DATA_W-1:0] sample_period
);

	logic [DATA_W-1:0] proc_noise_q;
	logic [DATA_W-1:0] meas_noise_q;
	logic [DATA_W-1:0] sample_period_q;
	logic              wr_en;
	logic [1:0]        reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_noise_q    <= RST_PROC_NOISE;
			meas_noise_q    <= RST_MEAS_NOISE;
			sample_period_q <= RST_SAMPLE_PERIOD;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PROC_NOISE:    proc_noise_q    <= pwdata;
				REG_MEAS_NOISE:    meas_noise_q    <= pwdata;
				REG_SAMPLE_PERIOD: sample_period_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PROC_NOISE:    prdata = proc_noise_q;
			REG_MEAS_NOISE:    prdata = meas_noise_q;
			REG_SAMPLE_PERIOD: prdata = sample_period_q;
			default:           prdata = '0;
		endcase
	end

	assign proc_noise    = proc_noise_q;
	assign meas_noise    = meas_noise_q;
	assign sample_period = sample_period_q;

endmodule
`default_nettype wire

### design/skaf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skaf_ctrl: sequencing state machine
// Steps one sample through predict, divide, update and output hand-off.
// ----------------------------------------------------------------------------
module skaf_ctrl
	import skaf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd
);

	state_t            state_q;
	state_t            state_nxt;
	logic [CNT_W-1:0]  cnt_q;
	logic              started_q;
	logic              out_valid_q;
	logic              slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_PRED;
			ST_PRED: state_nxt = ST_PADD;
			ST_PADD: state_nxt = ST_DIV;
			ST_DIV:  if (cnt_q == DIV_LAST) state_nxt = ST_GAIN;
			ST_GAIN: state_nxt = ST_GMUL;
			ST_GMUL: state_nxt = ST_UPD;
			ST_UPD:  state_nxt = ST_CMUL;
			ST_CMUL: state_nxt = ST_COV;
			ST_COV:  state_nxt = ST_DONE;
			ST_DONE: if (slot_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load     = in_valid;
				cmd.init_est = in_valid && !started_q;
			end
			ST_PRED: begin
				cmd.pred_mul = 1'b1;
				cmd.p_load   = 1'b1;
			end
			ST_PADD: begin
				cmd.pred_add = 1'b1;
				cmd.div_init = 1'b1;
			end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_GAIN: cmd.k_set    = 1'b1;
			ST_GMUL: cmd.gain_mul = 1'b1;
			ST_UPD:  cmd.gain_add = 1'b1;
			ST_CMUL: cmd.cov_mul  = 1'b1;
			ST_COV:  cmd.cov_upd  = 1'b1;
			ST_DONE: cmd.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load) begin
				started_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_mul_sel: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.pred_mul, cmd.gain_mul, cmd.cov_mul}))
		else $error("multiplier operand selects overlap");

	a_accept_pred: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_PRED))
		else $error("accepted beat not followed by prediction");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == DIV_LAST) |=> (state_q == ST_GAIN))
		else $error("divide did not end after its last step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> slot_free)
		else $error("result register overwritten while full");

	a_started_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q)
		else $error("started flag cleared outside reset");

endmodule
`default_nettype wire

### design/skaf_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skaf_dpath: filter datapath
// Shared 33x33 multiplier, restoring divider for the gain, estimate and
// covariance state, result register.
// ----------------------------------------------------------------------------
module skaf_dpath
	import skaf_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmd_t                     cmd,
	input  wire logic signed [DATA_W-1:0] angle_meas,
	input  wire logic signed [DATA_W-1:0] rate_meas,
	input  wire logic        [DATA_W-1:0] proc_noise,
	input  wire logic        [DATA_W-1:0] meas_noise,
	input  wire logic        [DATA_W-1:0] sample_period,
	output logic signed      [DATA_W-1:0] angle_est
);

	logic signed [31:0] angle_q;
	logic signed [31:0] rate_q;
	logic signed [31:0] est_q;
	logic        [31:0] cov_q;
	logic        [31:0] p_q;
	logic        [31:0] k_q;
	logic signed [65:0] prod_q;
	logic        [32:0] rem_q;
	logic        [32:0] dvs_q;
	logic        [31:0] quo_q;
	logic signed [31:0] angle_est_q;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [32:0] innov;
	logic        [32:0] p_sum;
	logic        [33:0] rem_sh;
	logic        [33:0] rem_sub;
	logic               rem_ge;

	assign innov   = {angle_q[31], angle_q} - {est_q[31], est_q};
	assign p_sum   = {1'b0, cov_q} + {1'b0, proc_noise};
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign rem_ge  = (rem_sh >= {1'b0, dvs_q});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.pred_mul) begin
			mul_a = {rate_q[31], rate_q};
			mul_b = {1'b0, sample_period};
		end else if (cmd.gain_mul) begin
			mul_a = innov;
			mul_b = {1'b0, k_q};
		end else if (cmd.cov_mul) begin
			mul_a = {1'b0, k_q};
			mul_b = {1'b0, p_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			angle_q <= angle_meas;
			rate_q  <= rate_meas;
		end
		if (cmd.pred_mul || cmd.gain_mul || cmd.cov_mul) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.p_load) begin
			p_q <= p_sum[32] ? '1 : p_sum[31:0];
		end
		if (cmd.div_init) begin
			rem_q <= {1'b0, p_q};
			dvs_q <= {1'b0, p_q} + {1'b0, meas_noise};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_ge) begin
				rem_q <= rem_sub[32:0];
			end else begin
				rem_q <= rem_sh[32:0];
			end
			quo_q <= {quo_q[30:0], rem_ge};
		end
		// R of zero: gain is all ones unless P is zero too
		if (cmd.k_set) begin
			if (meas_noise == '0) begin
				k_q <= (p_q == '0) ? '0 : '1;
			end else begin
				k_q <= quo_q;
			end
		end
		if (cmd.out_load) begin
			angle_est_q <= est_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= '0;
			cov_q <= RST_COVARIANCE;
		end else begin
			if (cmd.init_est) begin
				est_q <= angle_meas;
			end else if (cmd.pred_add || cmd.gain_add) begin
				est_q <= sat_add(est_q, prod_q[65:32]);
			end
			// (1-k)P rounded down = P - ceil(kP)
			if (cmd.cov_upd) begin
				cov_q <= p_q - prod_q[63:32] - {31'd0, (prod_q[31:0] != '0)};
			end
		end
	end

	assign angle_est = angle_est_q;

endmodule
`default_nettype wire

### design/scalar_kalman_angle_fusion.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scalar_kalman_angle_fusion: one-dimensional Kalman tilt filter
// Fuses a measured angle with a gyro rate into a filtered angle estimate.
//
// Input channel: in_valid/in_ready carry angle_meas and rate_meas (Q16.16).
// Output channel: out_valid/out_ready carry angle_est (Q16.16, saturated),
// exactly one result beat per input beat, in order.
// From acceptance to its result being presented, an item passes through
// predict and covariance, a 32-step restoring divide for the gain, gain,
// correction and covariance update, and output hand-off. The next item is
// taken only after hand-off of the previous one; the divider sets the pace.
// The result sits in an output register, so a new beat is accepted while
// it waits; if the receiver still holds the previous result when a new
// one is ready, the sequencer waits at hand-off until the slot frees.
// Reset clears the estimate, sets covariance to about one millionth and
// loads the register defaults; the first beat after reset seeds the
// estimate from its angle. The user must write Q, R and period over the APB
// port at 0x0, 0x4 and 0x8 only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module scalar_kalman_angle_fusion
	import skaf_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [DATA_W-1:0] angle_meas,
	input  wire logic signed [DATA_W-1:0] rate_meas,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed      [DATA_W-1:0] angle_est,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic        [ADDR_W-1:0] paddr,
	input  wire logic        [DATA_W-1:0] pwdata,
	output logic             [DATA_W-1:0] prdata,
	output logic                          pready
);

	cmd_t              cmd;
	logic [DATA_W-1:0] proc_noise;
	logic [DATA_W-1:0] meas_noise;
	logic [DATA_W-1:0] sample_period;

	skaf_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.proc_noise   (proc_noise),
		.meas_noise   (meas_noise),
		.sample_period(sample_period)
	);

	skaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	skaf_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.angle_meas   (angle_meas),
		.rate_meas    (rate_meas),
		.proc_noise   (proc_noise),
		.meas_noise   (meas_noise),
		.sample_period(sample_period),
		.angle_est    (angle_est)
	);

endmodule
`default_nettype wire

### tb/scalar_kalman_angle_fusion_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_angle_fusion_tb: self-checking bench for the angle filter
// Drives angle/rate samples through the valid/ready input channel, programs
// Q, R and the sample period over APB and checks every filtered estimate
// against a bit-exact fixed-point model of the Kalman recursion. Directed
// corner samples come first, then random phases, each under a new register
// setting, with random stalls on both channels in all phases but one.
// ----------------------------------------------------------------------------
module scalar_kalman_angle_fusion_tb;
	import skaf_pkg::*;

	class angle_scoreboard;
		logic [DATA_W-1:0] q_noise, r_noise, period;
		logic signed [31:0] est;
		logic [31:0] cov;
		bit seeded;
		logic signed [31:0] expected_est[$];
		int unsigned noted, checked, errors;

		function new();
			q_noise = RST_PROC_NOISE;
			r_noise = RST_MEAS_NOISE;
			period  = RST_SAMPLE_PERIOD;
			est     = '0;
			cov     = RST_COVARIANCE;
			seeded  = 1'b0;
			noted   = 0;
			checked = 0;
			errors  = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_PROC_NOISE: q_noise = val;
				REG_MEAS_NOISE: r_noise = val;
				REG_SAMPLE_PERIOD: period = val;
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [1:0] idx);
			case (idx)
				REG_PROC_NOISE: return q_noise;
				REG_MEAS_NOISE: return r_noise;
				default: return period;
			endcase
		endfunction

		function void fault(string what);
			errors++;
			if (errors <= 10) begin
				$display("MISMATCH at %0t: %s", $realtime, what);
			end
		endfunction

		// floor(s * u / 2^32), signed by unsigned 0.32
		function logic signed [33:0] scale_floor(logic signed [32:0] s, logic [31:0] u);
			logic signed [65:0] prod;
			prod = $signed({{33{s[32]}}, s}) * $signed({34'd0, u});
			return prod[65:32];
		endfunction

		function logic signed [31:0] clamp(logic signed [35:0] v);
			if (v > 36'sd2147483647) begin
				return 32'sh7fffffff;
			end else if (v < -36'sd2147483648) begin
				return 32'sh80000000;
			end
			return v[31:0];
		endfunction

		function void note_sample(logic signed [31:0] angle, logic signed [31:0] rate);
			logic [32:0] p;
			logic [33:0] denom;
			logic [64:0] gain_wide;
			logic [31:0] gain;
			logic signed [32:0] innov;
			logic signed [33:0] inc;
			logic [64:0] cov_wide;
			if (!seeded) begin
				est = angle;
				seeded = 1'b1;
			end
			inc = scale_floor({rate[31], rate}, period);
			est = clamp($signed({{4{est[31]}}, est}) + $signed({{2{inc[33]}}, inc}));
			p = {1'b0, cov} + {1'b0, q_noise};
			if (p[32]) begin
				p = 33'h0_ffff_ffff;
			end
			denom = {1'b0, p} + {2'b0, r_noise};
			if (denom == '0) begin
				gain = '0;
			end else begin
				gain_wide = {p, 32'd0} / {31'd0, denom};
				gain = (gain_wide > 65'h0_ffff_ffff) ? 32'hffff_ffff : gain_wide[31:0];
			end
			innov = {angle[31], angle} - {est[31], est};
			inc = scale_floor(innov, gain);
			est = clamp($signed({{4{est[31]}}, est}) + $signed({{2{inc[33]}}, inc}));
			cov_wide = (65'h1_0000_0000 - {33'd0, gain}) * {33'd0, p[31:0]};
			cov = cov_wide[63:32];
			expected_est.push_back(est);
			noted++;
		endfunction

		function void check_est(logic signed [31:0] got);
			logic signed [31:0] want;
			if (expected_est.size() == 0) begin
				fault($sformatf("angle_est beat %h with no sample outstanding", got));
			end else begin
				want = expected_est.pop_front();
				checked++;
				if (got !== want) begin
					fault($sformatf("angle_est expected %h got %h", want, got));
				end
			end
		endfunction

		function int pending();
			return expected_est.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready;
	logic signed [DATA_W-1:0] angle_meas, rate_meas;
	logic out_valid, out_ready;
	logic signed [DATA_W-1:0] angle_est;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	logic pready;

	angle_scoreboard sb;
	bit gaps_on = 1'b1;
	int unsigned settings;

	scalar_kalman_angle_fusion DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.angle_meas(angle_meas),
		.rate_meas(rate_meas),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.angle_est(angle_est),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= gaps_on ? ($urandom_range(0, 99) >= 14) : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_sample(angle_meas, rate_meas);
			end
			if (out_valid && out_ready) begin
				sb.check_est(angle_est);
			end
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic apb_access(input logic write, input logic [1:0] idx,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
	endtask

	task automatic readback(input logic [1:0] idx);
		logic [31:0] rd;
		apb_access(1'b0, idx, '0, rd);
		if (rd !== sb.reg_value(idx)) begin
			sb.fault($sformatf("register %0d read %h, expected %h", idx, rd,
					sb.reg_value(idx)));
		end
	endtask

	task automatic program_filter(input logic [31:0] q, input logic [31:0] r,
			input logic [31:0] t);
		logic [31:0] rd;
		apb_access(1'b1, REG_PROC_NOISE, q, rd);
		sb.set_reg(REG_PROC_NOISE, q);
		apb_access(1'b1, REG_MEAS_NOISE, r, rd);
		sb.set_reg(REG_MEAS_NOISE, r);
		apb_access(1'b1, REG_SAMPLE_PERIOD, t, rd);
		sb.set_reg(REG_SAMPLE_PERIOD, t);
		readback(REG_PROC_NOISE);
		readback(REG_MEAS_NOISE);
		readback(REG_SAMPLE_PERIOD);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings++;
	endtask

	// one input beat; enters and leaves at a falling edge with valid still high
	task automatic send_sample(input logic signed [31:0] a, input logic signed [31:0] r);
		while (gaps_on && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		angle_meas <= a;
		rate_meas <= r;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] extreme_word();
		case ($urandom_range(0, 4))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return 32'h0000_0001;
		endcase
	endfunction

	function automatic logic [31:0] noise_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return $urandom_range(0, 65535);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int track;
		int phase;
		int n;
		logic signed [31:0] a, r;
		sb = new();
		settings = 1;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		angle_meas <= '0;
		rate_meas <= '0;
		out_ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults, estimate seeding and saturation at both rails
		readback(REG_PROC_NOISE);
		readback(REG_MEAS_NOISE);
		readback(REG_SAMPLE_PERIOD);
		psel <= 1'b0;
		send_sample(32'sh7fffffff, 32'sh7fffffff);
		send_sample(32'sh7fffffff, 32'sh7fffffff);
		send_sample(32'sh80000000, 32'sh80000000);
		send_sample(32'sh80000000, 32'sh80000000);
		send_sample(32'sh00000000, 32'sh00000000);
		send_sample(32'shffffffff, 32'shffffffff);
		send_sample(32'sh00010000, 32'sh00000000);
		send_sample(32'sh00008000, 32'shffff0000);
		drain();

		// R = 0: unity gain, then covariance and R both zero
		program_filter(32'h0, 32'h0, 32'hffff_ffff);
		send_sample(32'sh12345678, 32'sh00100000);
		send_sample(32'sh12345678, 32'sh00000000);
		send_sample(32'sh80000000, 32'sh7fffffff);
		send_sample(32'sh00000000, 32'sh00000000);
		drain();

		// all registers at full scale: covariance saturates
		program_filter(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_sample(32'sh7fffffff, 32'sh7fffffff);
		send_sample(32'sh80000000, 32'sh80000000);
		send_sample(32'sh40000000, 32'sh40000000);
		send_sample(32'shc0000000, 32'sh7fffffff);
		drain();

		program_filter(32'h1, 32'h1, 32'h0);
		send_sample(32'sh00640000, 32'sh7fffffff);
		send_sample(32'shff9c0000, 32'sh80000000);
		send_sample(32'sh55555555, 32'shaaaaaaaa);
		drain();

		track = 0;
		for (phase = 0; phase < 8; phase++) begin
			if (phase == 0) begin
				program_filter(RST_PROC_NOISE, RST_MEAS_NOISE, RST_SAMPLE_PERIOD);
			end else begin
				program_filter(noise_word(), noise_word(), noise_word());
			end
			gaps_on = (phase != 3);
			for (n = 0; n < 100; n++) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						a = $urandom;
						r = $urandom;
					end
					2: begin
						a = extreme_word();
						r = extreme_word();
					end
					default: begin
						r = int'($urandom_range(0, 2 * 65536 * 50)) - 65536 * 50;
						track = track + int'($urandom_range(0, 2 * 65536)) - 65536;
						a = track + int'($urandom_range(0, 65536)) - 32768;
					end
				endcase
				send_sample(a, r);
			end
			drain();
		end
		gaps_on = 1'b1;

		repeat (60) @(posedge clk);
		$display("Ran %0d samples under %0d register settings, %0d estimates checked.",
				sb.noted, settings, sb.checked);
		$display("Mismatches: %0d, estimates still outstanding: %0d.", sb.errors,
				sb.pending());
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

### sim.f
design/skaf_pkg.sv
design/skaf_regs.sv
design/skaf_ctrl.sv
design/skaf_dpath.sv
design/scalar_kalman_angle_fusion.sv
tb/scalar_kalman_angle_fusion_tb.sv
